// ===== hdl/sha1h_pkg.sv =====
// Shared types and constants for the SHA-1 / HMAC-SHA-1 byte stream hasher.
// Used by the controller, the datapath and the top level.
package sha1h_pkg;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_KEY   = 2'd1;
    localparam logic [1:0] ACT_MSG   = 2'd2;
    localparam logic [1:0] ACT_FIN   = 2'd3;

    // byte sources for the block shifter
    localparam logic [2:0] SRC_IN    = 3'd0;
    localparam logic [2:0] SRC_KEY   = 3'd1;
    localparam logic [2:0] SRC_KEY_I = 3'd2;
    localparam logic [2:0] SRC_KEY_O = 3'd3;
    localparam logic [2:0] SRC_INNER = 3'd4;
    localparam logic [2:0] SRC_PAD   = 3'd5;
    localparam logic [2:0] SRC_ZERO  = 3'd6;
    localparam logic [2:0] SRC_LEN   = 3'd7;

    typedef struct packed {
        logic       take;
        logic       feed;
        logic       count;
        logic [2:0] src;
        logic [2:0] sel;
        logic       key_wr;
        logic [5:0] key_idx;
        logic       key_load;
        logic       start_hash;
        logic       clear_all;
        logic       save_inner;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic       busy;
        logic [5:0] fill;
        logic       out_free;
    } t_dp_stat;

endpackage

// ===== hdl/sha1_hmac_byte_stream.sv =====
// Top level of the SHA-1 / HMAC-SHA-1 byte stream hasher.
// Instantiates sha1h_ctrl and sha1h_dp; depends on sha1h_pkg.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser[1:0] action, tdata[7:0] data_byte
//  m_axis    out        tdata: digest_word, word_index, length_overflow; tlast last_word
//  apb       in/out     register 0 at address 0: hmac_mode (bit 0)
//
// A message byte passes through S_FEEDIN, a stored or dropped key byte does not; the 65th
// key byte first replays the 64 stored ones. A full 64-byte block starts 80 rounds and an
// add. A finish pads and closes one hash (two in HMAC mode, the outer over 84 bytes)
// and then offers five digest transactions, one per cycle when the sink is ready.
// s_axis_tready is low while a compression or a multi-step sequence runs.
// Reset is synchronous, active low; it clears the key store and restores the IV.
module sha1_hmac_byte_stream
    import sha1h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index,
                                       // [35] length_overflow, [39:36] zero
    output logic        m_axis_tlast,  // last_word
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     mode;
    logic     cfg_wr;

    // register written in the access phase of an APB write
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, mode} : 32'd0;

    sha1h_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_action   (s_axis_tuser),
        .o_ready    (s_axis_tready),
        .i_cfg_wr   (cfg_wr),
        .i_cfg_sel0 (paddr[2] == 1'b0),
        .i_cfg_bit  (pwdata[0]),
        .o_mode     (mode),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sha1h_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_byte  (s_axis_tdata),
        .o_stat  (stat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== hdl/sha1h_ctrl.sv =====
// Sequencer for the SHA-1 / HMAC hasher: input decode, padding and HMAC steps.
// Also holds the configuration register. Depends on sha1h_pkg.
module sha1h_ctrl
    import sha1h_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    output logic       o_ready,
    input  logic       i_cfg_wr,
    input  logic       i_cfg_sel0,
    input  logic       i_cfg_bit,
    output logic       o_mode,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_KEYRAW = 4'd1;
    localparam logic [3:0] S_FEEDIN = 4'd2;
    localparam logic [3:0] S_ENT    = 4'd3;
    localparam logic [3:0] S_PAD80  = 4'd4;
    localparam logic [3:0] S_PADZ   = 4'd5;
    localparam logic [3:0] S_LEN    = 4'd6;
    localparam logic [3:0] S_CDONE  = 4'd7;
    localparam logic [3:0] S_IPAD   = 4'd8;
    localparam logic [3:0] S_OPAD   = 4'd9;
    localparam logic [3:0] S_INNERB = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    localparam logic [1:0] STG_KEY   = 2'd0;
    localparam logic [1:0] STG_INNER = 2'd1;
    localparam logic [1:0] STG_OUTER = 2'd2;

    localparam logic [6:0] KEY_FULL = 7'd64;
    localparam logic [6:0] KEY_LONG = 7'd65;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [6:0] r_kc, n_kc;
    logic       r_phase, n_phase;
    logic       r_fin, n_fin;
    logic [1:0] r_stage, n_stage;
    logic       r_mode;
    logic       take;

    assign o_mode  = r_mode;
    assign o_ready = (r_state == S_IDLE) && !i_stat.busy;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_kc    <= '0;
            r_phase <= 1'b0;
            r_fin   <= 1'b0;
            r_stage <= STG_OUTER;
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kc    <= n_kc;
            r_phase <= n_phase;
            r_fin   <= n_fin;
            r_stage <= n_stage;
            if (i_cfg_wr && i_cfg_sel0) begin
                r_mode <= i_cfg_bit;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_kc    = r_kc;
        n_phase = r_phase;
        n_fin   = r_fin;
        n_stage = r_stage;
        o_cmd   = '0;
        o_cmd.take    = take;
        o_cmd.key_idx = r_kc[5:0];
        o_cmd.sel     = r_cnt[2:0];
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_action)
                        ACT_BEGIN: begin
                            o_cmd.clear_all = 1'b1;
                            n_kc    = '0;
                            n_phase = 1'b0;
                        end
                        ACT_KEY: begin
                            if (r_mode && !r_phase) begin
                                if (r_kc < KEY_FULL) begin
                                    o_cmd.key_wr = 1'b1;
                                    n_kc = r_kc + 7'd1;
                                end else if (r_kc == KEY_FULL) begin
                                    o_cmd.start_hash = 1'b1;
                                    n_kc    = KEY_LONG;
                                    n_cnt   = '0;
                                    n_state = S_KEYRAW;
                                end else begin
                                    n_state = S_FEEDIN;
                                end
                            end
                        end
                        ACT_MSG: begin
                            if (r_mode && !r_phase) begin
                                n_fin   = 1'b0;
                                n_state = S_ENT;
                            end else begin
                                n_phase = 1'b1;
                                n_state = S_FEEDIN;
                            end
                        end
                        ACT_FIN: begin
                            if (r_mode && !r_phase) begin
                                n_fin   = 1'b1;
                                n_state = S_ENT;
                            end else begin
                                n_stage = r_mode ? STG_INNER : STG_OUTER;
                                n_state = S_PAD80;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_KEYRAW: begin
                if (!i_stat.busy) begin
                    o_cmd.feed  = 1'b1;
                    o_cmd.count = 1'b1;
                    o_cmd.src   = SRC_KEY;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        n_state = S_FEEDIN;
                    end
                end
            end
            S_FEEDIN: begin
                if (!i_stat.busy) begin
                    o_cmd.feed  = 1'b1;
                    o_cmd.count = 1'b1;
                    o_cmd.src   = SRC_IN;
                    n_state = S_IDLE;
                end
            end
            S_ENT: begin
                if (!i_stat.busy) begin
                    if (r_kc == KEY_LONG) begin
                        n_stage = STG_KEY;
                        n_state = S_PAD80;
                    end else begin
                        o_cmd.start_hash = 1'b1;
                        n_cnt   = '0;
                        n_state = S_IPAD;
                    end
                end
            end
            S_PAD80: begin
                if (!i_stat.busy) begin
                    o_cmd.feed = 1'b1;
                    o_cmd.src  = SRC_PAD;
                    n_state = S_PADZ;
                end
            end
            S_PADZ: begin
                if (!i_stat.busy) begin
                    if (i_stat.fill == 6'd56) begin
                        n_cnt   = '0;
                        n_state = S_LEN;
                    end else begin
                        o_cmd.feed = 1'b1;
                        o_cmd.src  = SRC_ZERO;
                    end
                end
            end
            S_LEN: begin
                if (!i_stat.busy) begin
                    o_cmd.feed = 1'b1;
                    o_cmd.src  = SRC_LEN;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd7) begin
                        n_state = S_CDONE;
                    end
                end
            end
            S_CDONE: begin
                if (!i_stat.busy) begin
                    n_cnt = '0;
                    case (r_stage)
                        STG_KEY: begin
                            o_cmd.key_load   = 1'b1;
                            o_cmd.start_hash = 1'b1;
                            n_state = S_IPAD;
                        end
                        STG_INNER: begin
                            o_cmd.save_inner = 1'b1;
                            o_cmd.start_hash = 1'b1;
                            n_state = S_OPAD;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_IPAD: begin
                if (!i_stat.busy) begin
                    o_cmd.feed  = 1'b1;
                    o_cmd.count = 1'b1;
                    o_cmd.src   = SRC_KEY_I;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        n_phase = 1'b1;
                        if (r_fin) begin
                            n_stage = STG_INNER;
                            n_state = S_PAD80;
                        end else begin
                            n_state = S_FEEDIN;
                        end
                    end
                end
            end
            S_OPAD: begin
                if (!i_stat.busy) begin
                    o_cmd.feed  = 1'b1;
                    o_cmd.count = 1'b1;
                    o_cmd.src   = SRC_KEY_O;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        n_cnt   = '0;
                        n_state = S_INNERB;
                    end
                end
            end
            S_INNERB: begin
                if (!i_stat.busy) begin
                    o_cmd.feed  = 1'b1;
                    o_cmd.count = 1'b1;
                    o_cmd.src   = SRC_INNER;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd19) begin
                        n_stage = STG_OUTER;
                        n_state = S_PAD80;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                    if (r_cnt == 6'd4) begin
                        o_cmd.clear_all = 1'b1;
                        n_kc    = '0;
                        n_phase = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/sha1h_dp.sv =====
// Datapath: block shifter, key store, round unit, chaining words, counters, output stage.
// Driven by commands from sha1h_ctrl. Depends on sha1h_pkg.
module sha1h_dp
    import sha1h_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_byte,
    output t_dp_stat    o_stat,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [39:0] o_data,
    output logic        o_last
);

    logic [511:0] r_blk;
    logic [511:0] r_key;
    logic [159:0] r_inner;
    logic [31:0]  r_h0, r_h1, r_h2, r_h3, r_h4;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [6:0]   r_rnd;
    logic         r_busy;
    logic [5:0]   r_fill;
    logic [31:0]  r_total;
    logic         r_wrap;
    logic [7:0]   r_byte;
    logic         r_ov;
    logic [39:0]  r_od;
    logic         r_ol;

    logic [7:0]  fb;
    logic [63:0] len_sh;
    logic [31:0] wnew, f, k, t, dword;

    function automatic logic [31:0] wd(input logic [511:0] b, input int n);
        wd = b[511-32*n -: 32];
    endfunction

    assign len_sh = {29'd0, r_total, 3'd0} << {i_cmd.sel, 3'b000};

    always_comb begin
        case (i_cmd.src)
            SRC_IN:    fb = r_byte;
            SRC_KEY:   fb = r_key[511:504];
            SRC_KEY_I: fb = r_key[511:504] ^ IPAD_BYTE;
            SRC_KEY_O: fb = r_key[511:504] ^ OPAD_BYTE;
            SRC_INNER: fb = r_inner[159:152];
            SRC_PAD:   fb = PAD_BYTE;
            SRC_ZERO:  fb = 8'd0;
            default:   fb = len_sh[63:56];
        endcase
    end

    assign wnew = {wd(r_blk, 13) ^ wd(r_blk, 8) ^ wd(r_blk, 2) ^ wd(r_blk, 0)};

    always_comb begin
        if (r_rnd < 7'd20) begin
            f = r_d ^ (r_b & (r_c ^ r_d));
            k = K0;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_d & (r_b | r_c));
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
        t = f + k + {r_a[26:0], r_a[31:27]} + r_e + wd(r_blk, 0);
    end

    always_comb begin
        case (i_cmd.sel)
            3'd0:    dword = r_h0;
            3'd1:    dword = r_h1;
            3'd2:    dword = r_h2;
            3'd3:    dword = r_h3;
            default: dword = r_h4;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_rnd   <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_wrap  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_busy) begin
                r_rnd <= r_rnd + 7'd1;
                if (r_rnd == 7'd80) begin
                    r_busy <= 1'b0;
                end
            end
            if (i_cmd.feed) begin
                r_fill <= r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    r_busy <= 1'b1;
                    r_rnd  <= '0;
                end
                if (i_cmd.count) begin
                    if (r_total == 32'hffffffff) begin
                        r_wrap <= 1'b1;
                    end
                    r_total <= r_total + 32'd1;
                end
            end
            if (i_cmd.start_hash || i_cmd.clear_all) begin
                r_fill  <= '0;
                r_total <= '0;
            end
            if (i_cmd.clear_all) begin
                r_wrap <= 1'b0;
            end
        end
    end

    // chaining words and key store carry reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0  <= IV0;
            r_h1  <= IV1;
            r_h2  <= IV2;
            r_h3  <= IV3;
            r_h4  <= IV4;
            r_key <= '0;
        end else begin
            if (r_busy && r_rnd == 7'd80) begin
                r_h0 <= r_h0 + r_a;
                r_h1 <= r_h1 + r_b;
                r_h2 <= r_h2 + r_c;
                r_h3 <= r_h3 + r_d;
                r_h4 <= r_h4 + r_e;
            end
            if (i_cmd.start_hash || i_cmd.clear_all) begin
                r_h0 <= IV0;
                r_h1 <= IV1;
                r_h2 <= IV2;
                r_h3 <= IV3;
                r_h4 <= IV4;
            end
            if (i_cmd.feed && (i_cmd.src == SRC_KEY || i_cmd.src == SRC_KEY_I ||
                               i_cmd.src == SRC_KEY_O)) begin
                r_key <= {r_key[503:0], r_key[511:504]};
            end
            if (i_cmd.key_wr) begin
                for (int i = 0; i < 64; i++) begin
                    if (i_cmd.key_idx == 6'(i)) begin
                        r_key[511-8*i -: 8] <= i_byte;
                    end
                end
            end
            if (i_cmd.key_load) begin
                r_key <= {r_h0, r_h1, r_h2, r_h3, r_h4, 352'd0};
            end
            if (i_cmd.clear_all) begin
                r_key <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_byte <= i_byte;
        end
        if (i_cmd.feed) begin
            r_blk <= {r_blk[503:0], fb};
            if (r_fill == 6'd63) begin
                r_a <= r_h0;
                r_b <= r_h1;
                r_c <= r_h2;
                r_d <= r_h3;
                r_e <= r_h4;
            end
        end
        if (r_busy && r_rnd != 7'd80) begin
            r_blk <= {r_blk[479:0], wnew[30:0], wnew[31]};
            r_e   <= r_d;
            r_d   <= r_c;
            r_c   <= {r_b[1:0], r_b[31:2]};
            r_b   <= r_a;
            r_a   <= t;
        end
        if (i_cmd.save_inner) begin
            r_inner <= {r_h0, r_h1, r_h2, r_h3, r_h4};
        end else if (i_cmd.feed && i_cmd.src == SRC_INNER) begin
            r_inner <= {r_inner[151:0], 8'd0};
        end
        if (i_cmd.out_load) begin
            r_od <= {4'd0, r_wrap, i_cmd.sel, dword};
            r_ol <= (i_cmd.sel == 3'd4);
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.fill     = r_fill;
    assign o_stat.out_free = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_data  = r_od;
    assign o_last  = r_ol;

endmodule

// ===== hdl/sha1h_checker.sv =====
// Port-level checks for sha1_hmac_byte_stream, attached by bind.
// Depends only on the top level's ports.
module sha1h_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // hold a stalled result transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == 3'd4)
        else $error("last word without index four");

    a_mid_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:32] == 3'd0 ||
            m_axis_tdata[34:32] == 3'd1 || m_axis_tdata[34:32] == 3'd2 ||
            m_axis_tdata[34:32] == 3'd3)
        else $error("bad word index");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind sha1_hmac_byte_stream sha1h_checker u_sha1h_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== dv/sha1_hmac_byte_stream_tb.sv =====
// Self-checking testbench for sha1_hmac_byte_stream: plain SHA-1 and HMAC-SHA-1 digests.
// Depends on sha1h_pkg for the action codes; an in-bench SHA-1 predictor checks each beat.
module sha1_hmac_byte_stream_tb;
    import sha1h_pkg::*;

    localparam logic [2:0] REG_HMAC_MODE = 3'd0;
    localparam logic [6:0] KEY_HASHING   = 7'd65;  // key count once a long key is being hashed

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
        logic        ovf;
    } t_digest_beat;

    // directed row: mode to hold, the transaction, and an optional known first digest word
    typedef struct packed {
        logic        mode;
        logic [1:0]  act;
        logic [7:0]  dbyte;
        logic        has_kat;
        logic [31:0] kat_w0;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic [1:0]  s_axis_tuser = '0;   // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [31:0] digest_word, [34:32] word_index, [35] overflow
    logic        m_axis_tlast;        // last_word
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    sha1_hmac_byte_stream u_top (.*);

    always #2 i_clk = ~i_clk;

    // Predicted state of the hasher
    logic        mode_q;
    logic [31:0] chain [5];
    logic [31:0] blk [16];
    logic [5:0]  fill;
    logic [31:0] total;
    logic [7:0]  key_mem [64];
    logic [6:0]  key_cnt;
    logic [31:0] inner [5];
    logic        in_msg;
    logic        wrapped;

    t_digest_beat digest_q [$];
    int err_count = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int phase_items = 0;

    function automatic logic [31:0] rol(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, t;
        int r;
        w = blk;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
        for (r = 0; r < 80; r++) begin
            if (r >= 16)
                w[r & 15] = rol(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
            if (r < 20)      f = (d ^ (b & (c ^ d))) + K0;
            else if (r < 40) f = (b ^ c ^ d) + K1;
            else if (r < 60) f = ((b & c) | (d & (b | c))) + K2;
            else             f = (b ^ c ^ d) + K3;
            t = f + rol(a, 5) + e + w[r & 15];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endtask

    task automatic sha_absorb(input logic [7:0] v);
        blk[fill[5:2]][8 * (3 - fill[1:0]) +: 8] = v;
        fill = fill + 6'd1;
        if (fill == 6'd0) sha_compress();
    endtask

    task automatic sha_feed(input logic [7:0] v);
        if (total == 32'hffff_ffff) wrapped = 1'b1;
        total = total + 32'd1;
        sha_absorb(v);
    endtask

    task automatic sha_start();
        chain = '{IV0, IV1, IV2, IV3, IV4};
        fill = '0;
        total = '0;
    endtask

    // pad with 0x80, zeros and the 64-bit bit length, then hand back the chaining words
    task automatic sha_close(output logic [31:0] dig [5]);
        logic [63:0] bits;
        int i;
        bits = {29'd0, total, 3'd0};
        sha_absorb(PAD_BYTE);
        while (fill != 6'd56) sha_absorb(8'h00);
        for (i = 7; i >= 0; i--) sha_absorb(bits[i * 8 +: 8]);
        dig = chain;
    endtask

    task automatic hash_clear();
        int i;
        sha_start();
        for (i = 0; i < 16; i++) blk[i] = '0;
        for (i = 0; i < 64; i++) key_mem[i] = '0;
        for (i = 0; i < 5; i++) inner[i] = '0;
        key_cnt = '0;
        in_msg = 1'b0;
        wrapped = 1'b0;
    endtask

    // close the key phase: fold a long key to its digest, then absorb key XOR ipad
    task automatic open_inner();
        logic [31:0] dig [5];
        int i;
        if (key_cnt == KEY_HASHING) begin
            sha_close(dig);
            for (i = 0; i < 64; i++)
                key_mem[i] = (i < 20) ? dig[i >> 2][8 * (3 - (i & 3)) +: 8] : 8'h00;
        end
        sha_start();
        for (i = 0; i < 64; i++) sha_feed(key_mem[i] ^ IPAD_BYTE);
        in_msg = 1'b1;
    endtask

    // advance the predicted state by one accepted transaction, queueing any digest beats
    task automatic predict_digest(input logic [1:0] act, input logic [7:0] v);
        logic [31:0] dig [5];
        int i;
        case (act)
            ACT_BEGIN: hash_clear();
            ACT_KEY: begin
                if (mode_q && !in_msg) begin
                    if (key_cnt < 7'd64) begin
                        key_mem[key_cnt[5:0]] = v;
                        key_cnt++;
                    end else if (key_cnt == 7'd64) begin
                        sha_start();
                        for (i = 0; i < 64; i++) sha_feed(key_mem[i]);
                        sha_feed(v);
                        key_cnt = KEY_HASHING;
                    end else begin
                        sha_feed(v);
                    end
                end
            end
            ACT_MSG: begin
                if (mode_q) begin
                    if (!in_msg) open_inner();
                end else begin
                    in_msg = 1'b1;
                end
                sha_feed(v);
            end
            default: begin
                if (mode_q) begin
                    if (!in_msg) open_inner();
                    sha_close(inner);
                    sha_start();
                    for (i = 0; i < 64; i++) sha_feed(key_mem[i] ^ OPAD_BYTE);
                    for (i = 0; i < 20; i++) sha_feed(inner[i >> 2][8 * (3 - (i & 3)) +: 8]);
                end
                sha_close(dig);
                for (i = 0; i < 5; i++)
                    digest_q.push_back('{dig[i], 3'(i), i == 4, wrapped});
                hash_clear();
            end
        endcase
    endtask

    // Offer one transaction, optionally after random idle cycles; return at the accepting edge
    task automatic send_item(input logic [1:0] act, input logic [7:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_digest(act, v);
        phase_items++;
    endtask

    // Hold until every digest beat has arrived and the block takes input again
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic write_mode(input logic m);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_HMAC_MODE;
        pwdata  <= {31'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_q = m;
    endtask

    // One random sequence: mostly begin / key / message / finish, sometimes a stray transaction
    task automatic random_sequence();
        int klen, mlen, i;
        if ($urandom_range(7) == 0) begin
            send_item(2'($urandom_range(3)), 8'($urandom));
            return;
        end
        if ($urandom_range(3) != 0) send_item(ACT_BEGIN, 8'($urandom));
        klen = ($urandom_range(7) == 0) ? $urandom_range(64, 68) : $urandom_range(0, 12);
        mlen = ($urandom_range(7) == 0) ? $urandom_range(55, 66) : $urandom_range(0, 12);
        for (i = 0; i < klen; i++) send_item(ACT_KEY, 8'($urandom));
        for (i = 0; i < mlen; i++) send_item(ACT_MSG, 8'($urandom));
        send_item(ACT_FIN, 8'($urandom));
    endtask

    // Sink: random back-pressure, refreshed every cycle
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Compare every accepted digest beat with the oldest prediction
    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest transaction: tdata %h", m_axis_tdata);
                err_count++;
            end else begin
                exp_beat = digest_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_beat.word) begin
                    $error("digest_word: expected %h, got %h", exp_beat.word, m_axis_tdata[31:0]);
                    err_count++;
                end
                if (m_axis_tdata[34:32] !== exp_beat.idx) begin
                    $error("word_index: expected %0d, got %0d", exp_beat.idx, m_axis_tdata[34:32]);
                    err_count++;
                end
                if (m_axis_tlast !== exp_beat.last) begin
                    $error("last_word: expected %b, got %b", exp_beat.last, m_axis_tlast);
                    err_count++;
                end
                if (m_axis_tdata[35] !== exp_beat.ovf) begin
                    $error("length_overflow: expected %b, got %b", exp_beat.ovf, m_axis_tdata[35]);
                    err_count++;
                end
            end
        end
    end

    // Directed rows; known first digest words for empty SHA-1, "abc" and empty-key HMAC
    t_stim_row directed [] = '{
        '{1'b0, ACT_FIN,   8'h00, 1'b1, 32'hda39a3ee},  // finish straight after reset
        '{1'b0, ACT_MSG,   8'h61, 1'b0, 32'h0},
        '{1'b0, ACT_MSG,   8'h62, 1'b0, 32'h0},
        '{1'b0, ACT_MSG,   8'h63, 1'b0, 32'h0},
        '{1'b0, ACT_FIN,   8'hff, 1'b1, 32'ha9993e36},
        '{1'b0, ACT_KEY,   8'hff, 1'b0, 32'h0},         // key in plain mode: dropped
        '{1'b0, ACT_MSG,   8'h00, 1'b0, 32'h0},
        '{1'b0, ACT_MSG,   8'hff, 1'b0, 32'h0},
        '{1'b0, ACT_BEGIN, 8'h5a, 1'b0, 32'h0},         // begin throws the message away
        '{1'b0, ACT_FIN,   8'h00, 1'b1, 32'hda39a3ee},
        '{1'b1, ACT_FIN,   8'h00, 1'b1, 32'hfbdb1d1b},  // HMAC finish in key phase
        '{1'b1, ACT_KEY,   8'h00, 1'b0, 32'h0},
        '{1'b1, ACT_KEY,   8'hff, 1'b0, 32'h0},
        '{1'b1, ACT_MSG,   8'h55, 1'b0, 32'h0},
        '{1'b1, ACT_KEY,   8'haa, 1'b0, 32'h0},         // key in message phase: dropped
        '{1'b1, ACT_MSG,   8'hff, 1'b0, 32'h0},
        '{1'b1, ACT_FIN,   8'h00, 1'b0, 32'h0},
        '{1'b1, ACT_KEY,   8'h11, 1'b0, 32'h0},
        '{1'b0, ACT_MSG,   8'h22, 1'b0, 32'h0},         // mode flipped mid-hash
        '{1'b0, ACT_FIN,   8'h00, 1'b0, 32'h0},
        '{1'b1, ACT_KEY,   8'h33, 1'b0, 32'h0},
        '{1'b1, ACT_FIN,   8'h00, 1'b0, 32'h0}
    };

    initial begin
        int p;
        mode_q = 1'b0;
        hash_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: switch mode only with the block drained
        foreach (directed[i]) begin
            if (directed[i].mode != mode_q) begin
                wait_idle();
                write_mode(directed[i].mode);
            end
            send_item(directed[i].act, directed[i].dbyte);
            if (directed[i].has_kat && digest_q[digest_q.size() - 5].word !== directed[i].kat_w0) begin
                $error("digest_word: expected %h, got %h", directed[i].kat_w0,
                       digest_q[digest_q.size() - 5].word);
                err_count++;
            end
        end

        // Random part: no idling, sender idle, sink stalling, both
        for (p = 0; p < 4; p++) begin
            wait_idle();
            write_mode(p == 1 || p == 2);
            send_idle_pct  = (p == 1) ? 70 : (p == 3) ? 33 : 0;
            sink_stall_pct = (p == 2) ? 70 : (p == 3) ? 33 : 0;
            phase_items = 0;
            while (phase_items < 15) random_sequence();
        end

        wait_idle();
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/sha1h_pkg.sv
hdl/sha1h_ctrl.sv
hdl/sha1h_dp.sv
hdl/sha1_hmac_byte_stream.sv
hdl/sha1h_checker.sv
dv/sha1_hmac_byte_stream_tb.sv
